@@ hdl/manifest_tokenizer_defines.svh @@
// Assertion macros shared by the tokenizer RTL.
`ifndef MANIFEST_TOKENIZER_DEFINES_SVH
`define MANIFEST_TOKENIZER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MTOK_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MTOK_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/mtok_pkg.sv @@
// Shared types and codes of the manifest tokenizer.
package mtok_pkg;

  localparam int KIND_W = 4;
  localparam int SPAN_W = 24;
  localparam int DIAG_W = 2;

  localparam logic [KIND_W-1:0] K_EOF     = 4'd0;
  localparam logic [KIND_W-1:0] K_NEWLINE = 4'd1;
  localparam logic [KIND_W-1:0] K_IDENT   = 4'd2;
  localparam logic [KIND_W-1:0] K_STRING  = 4'd3;
  localparam logic [KIND_W-1:0] K_ERROR   = 4'd4;
  localparam logic [KIND_W-1:0] K_LBRACE  = 4'd5;
  localparam logic [KIND_W-1:0] K_RBRACE  = 4'd6;
  localparam logic [KIND_W-1:0] K_LBRACK  = 4'd7;
  localparam logic [KIND_W-1:0] K_RBRACK  = 4'd8;
  localparam logic [KIND_W-1:0] K_COLON   = 4'd9;
  localparam logic [KIND_W-1:0] K_SEMI    = 4'd10;
  localparam logic [KIND_W-1:0] K_COMMA   = 4'd11;
  localparam logic [KIND_W-1:0] K_DIAG    = 4'd12;

  localparam logic [DIAG_W-1:0] D_NONE         = 2'd0;
  localparam logic [DIAG_W-1:0] D_MULTILINE    = 2'd1;
  localparam logic [DIAG_W-1:0] D_UNTERMINATED = 2'd2;
  localparam logic [DIAG_W-1:0] D_UNRECOGNIZED = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SPAN_W-1:0] span_start;
    logic [SPAN_W-1:0] span_end;
    logic [DIAG_W-1:0] diag;
  } mtok_res_t;

  // All results of one input item: first, and an optional second.
  typedef struct packed {
    mtok_res_t first;
    mtok_res_t second;
    logic      two;
  } mtok_bundle_t;

endpackage

@@ hdl/mtok_ifs.sv @@
// Valid/ready channel interfaces of the manifest tokenizer.
interface mtok_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] source_byte;

  modport source (output valid, output op, output source_byte, input ready);
  modport sink (input valid, input op, input source_byte, output ready);
endinterface

interface mtok_out_if import mtok_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] token_kind;
  logic [SPAN_W-1:0] span_start;
  logic [SPAN_W-1:0] span_end;
  logic [DIAG_W-1:0] diagnostic;
  logic              last_of_run;

  modport source (output valid, output token_kind, output span_start, output span_end,
                  output diagnostic, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input span_start, input span_end,
                input diagnostic, input last_of_run, output ready);
endinterface

@@ hdl/mtok_front.sv @@
// Front end: accepts bytes, runs the lexer mode machine, builds result bundles.
module mtok_front import mtok_pkg::*; #(
  parameter int POSITION_WIDTH = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  mtok_in_if.sink      in_ch,
  input  logic         q_full,
  output logic         q_push,
  output mtok_bundle_t q_data
);

  typedef logic [POSITION_WIDTH-1:0] pos_t;

  localparam pos_t PosMax = {POSITION_WIDTH{1'b1}};

  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0b;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_UNDER  = 8'h5f;

  typedef enum logic [6:0] {
    MODE_IDLE    = 7'b0000001,
    MODE_SLASH   = 7'b0000010,
    MODE_SLASH2  = 7'b0000100,
    MODE_COMMENT = 7'b0001000,
    MODE_CR      = 7'b0010000,
    MODE_IDENT   = 7'b0100000,
    MODE_STRING  = 7'b1000000
  } mode_t;

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
  endfunction

  function automatic logic is_ident_char(input logic [7:0] b);
    return b == CH_UNDER || is_letter(b) || (b >= 8'h30 && b <= 8'h39);
  endfunction

  function automatic mtok_res_t mk_res(input logic [KIND_W-1:0] kind, input pos_t s,
                                       input pos_t e, input logic [DIAG_W-1:0] diag);
    mtok_res_t r;
    r.kind       = kind;
    r.span_start = SPAN_W'(s);
    r.span_end   = SPAN_W'(e);
    r.diag       = diag;
    return r;
  endfunction

  mode_t mode_r, mode_nxt;
  pos_t  begin_r, begin_nxt;
  pos_t  pos_r, pos_nxt;

  logic       accept;
  logic [7:0] b;
  pos_t       p, np;
  logic       line_break;

  // result of lexing the byte from idle
  mode_t      idle_mode;
  logic       idle_emit;
  mtok_res_t  idle_res;

  logic       go_idle;
  logic       pend_v, lead_v;
  mtok_res_t  pend, lead;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.source_byte;
  assign p           = pos_r;
  assign np          = (pos_r == PosMax) ? pos_r : pos_r + pos_t'(1);
  assign line_break  = (b == CH_CR) || (b == CH_LF);

  always_comb begin
    idle_mode = MODE_IDLE;
    idle_emit = 1'b0;
    idle_res  = mk_res(K_ERROR, p, np, D_UNRECOGNIZED);
    unique case (b) inside
      CH_SP, CH_TAB, CH_VT, CH_FF: ;
      CH_SLASH:  idle_mode = MODE_SLASH;
      CH_CR:     idle_mode = MODE_CR;
      CH_QUOTE:  idle_mode = MODE_STRING;
      CH_LF: begin
        idle_emit = 1'b1;
        idle_res  = mk_res(K_NEWLINE, p, np, D_NONE);
      end
      CH_LBRACE: begin
        idle_emit = 1'b1;
        idle_res  = mk_res(K_LBRACE, p, np, D_NONE);
      end
      CH_RBRACE: begin
        idle_emit = 1'b1;
        idle_res  = mk_res(K_RBRACE, p, np, D_NONE);
      end
      CH_LBRACK: begin
        idle_emit = 1'b1;
        idle_res  = mk_res(K_LBRACK, p, np, D_NONE);
      end
      CH_RBRACK: begin
        idle_emit = 1'b1;
        idle_res  = mk_res(K_RBRACK, p, np, D_NONE);
      end
      CH_COLON: begin
        idle_emit = 1'b1;
        idle_res  = mk_res(K_COLON, p, np, D_NONE);
      end
      CH_SEMI: begin
        idle_emit = 1'b1;
        idle_res  = mk_res(K_SEMI, p, np, D_NONE);
      end
      CH_COMMA: begin
        idle_emit = 1'b1;
        idle_res  = mk_res(K_COMMA, p, np, D_NONE);
      end
      default: begin
        if (b == CH_UNDER || is_letter(b)) begin
          idle_mode = MODE_IDENT;
        end else begin
          idle_emit = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    mode_nxt  = mode_r;
    begin_nxt = begin_r;
    pos_nxt   = pos_r;
    go_idle   = 1'b0;
    pend_v    = 1'b0;
    pend      = mk_res(K_ERROR, begin_r, p, D_UNRECOGNIZED);
    lead_v    = 1'b0;
    lead      = idle_res;
    if (in_ch.op) begin
      // end of input: flush pending token, then EOF, then back to reset state
      unique case (mode_r)
        MODE_SLASH: pend_v = 1'b1;
        MODE_CR: begin
          pend_v = 1'b1;
          pend   = mk_res(K_NEWLINE, begin_r, p, D_NONE);
        end
        MODE_IDENT: begin
          pend_v = 1'b1;
          pend   = mk_res(K_IDENT, begin_r, p, D_NONE);
        end
        MODE_STRING: begin
          pend_v = 1'b1;
          pend   = mk_res(K_ERROR, begin_r, p, D_UNTERMINATED);
        end
        default: ;
      endcase
      lead_v    = 1'b1;
      lead      = mk_res(K_EOF, p, p, D_NONE);
      mode_nxt  = MODE_IDLE;
      begin_nxt = '0;
      pos_nxt   = '0;
    end else begin
      unique case (mode_r)
        MODE_SLASH: begin
          if (b == CH_SLASH) begin
            mode_nxt = MODE_SLASH2;
          end else begin
            pend_v  = 1'b1;
            go_idle = 1'b1;
          end
        end
        MODE_SLASH2: begin
          if (line_break) begin
            go_idle = 1'b1;
          end else begin
            // "//{" gets flagged as a block comment attempt
            if (b == CH_LBRACE) begin
              pend_v = 1'b1;
              pend   = mk_res(K_DIAG, begin_r, np, D_MULTILINE);
            end
            mode_nxt = MODE_COMMENT;
          end
        end
        MODE_COMMENT: go_idle = line_break;
        MODE_CR: begin
          pend_v = 1'b1;
          if (b == CH_LF) begin
            pend     = mk_res(K_NEWLINE, begin_r, np, D_NONE);
            mode_nxt = MODE_IDLE;
          end else begin
            pend    = mk_res(K_NEWLINE, begin_r, p, D_NONE);
            go_idle = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (!is_ident_char(b)) begin
            pend_v  = 1'b1;
            pend    = mk_res(K_IDENT, begin_r, p, D_NONE);
            go_idle = 1'b1;
          end
        end
        MODE_STRING: begin
          if (b == CH_QUOTE) begin
            pend_v   = 1'b1;
            pend     = mk_res(K_STRING, begin_r, np, D_NONE);
            mode_nxt = MODE_IDLE;
          end else if (line_break) begin
            pend_v  = 1'b1;
            pend    = mk_res(K_ERROR, begin_r, p, D_UNTERMINATED);
            go_idle = 1'b1;
          end
        end
        default: go_idle = 1'b1;
      endcase
      if (go_idle) begin
        mode_nxt  = idle_mode;
        begin_nxt = p;
        lead_v    = idle_emit;
      end
      pos_nxt = np;
    end
  end

  assign q_push        = accept && (pend_v || lead_v);
  assign q_data.first  = pend_v ? pend : lead;
  assign q_data.second = lead;
  assign q_data.two    = pend_v && lead_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      begin_r <= '0;
      pos_r   <= '0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      begin_r <= begin_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

@@ hdl/mtok_queue.sv @@
// Small FIFO of result bundles between front and back end.
module mtok_queue import mtok_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  mtok_bundle_t push_data,
  output logic         full,
  input  logic         pop,
  output logic         pop_valid,
  output mtok_bundle_t pop_data
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  mtok_bundle_t    mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign full      = (count_r == FullCnt);
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastIdx) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastIdx) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ hdl/mtok_back.sv @@
// Back end: splits bundles into single result beats behind an output register.
module mtok_back import mtok_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_valid,
  input  mtok_bundle_t q_data,
  output logic         q_pop,
  mtok_out_if.source   out_ch
);

  logic      out_valid_r, out_valid_nxt;
  mtok_res_t out_res_r, out_res_nxt;
  logic      out_last_r, out_last_nxt;
  logic      hold_v_r, hold_v_nxt;
  mtok_res_t hold_r, hold_nxt;
  logic      load_ok;

  // output register free or being drained this cycle
  assign load_ok = !out_valid_r || out_ch.ready;
  assign q_pop   = load_ok && !hold_v_r && q_valid;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    out_last_nxt  = out_last_r;
    hold_v_nxt    = hold_v_r;
    hold_nxt      = hold_r;
    if (load_ok) begin
      if (hold_v_r) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = hold_r;
        out_last_nxt  = 1'b1;
        hold_v_nxt    = 1'b0;
      end else if (q_valid) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = q_data.first;
        out_last_nxt  = !q_data.two;
        hold_v_nxt    = q_data.two;
        hold_nxt      = q_data.second;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      hold_v_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      hold_v_r    <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    out_last_r <= out_last_nxt;
    hold_r     <= hold_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.token_kind  = out_res_r.kind;
  assign out_ch.span_start  = out_res_r.span_start;
  assign out_ch.span_end    = out_res_r.span_end;
  assign out_ch.diagnostic  = out_res_r.diag;
  assign out_ch.last_of_run = out_last_r;

endmodule

@@ hdl/manifest_tokenizer.sv @@
// An accepted beat's results pass through the bundle queue and then the output
//   register. One input beat is taken per cycle while the queue is not full; an item
//   with two results leaves as two output beats, absorbed by the 4-entry bundle queue.
// Reset (rst_n low, synchronous): lexer idle, positions zero, queue and
//   output register empty.
`include "manifest_tokenizer_defines.svh"

module manifest_tokenizer import mtok_pkg::*; #(
  parameter int POSITION_WIDTH = 24
) (
  input logic        clk,
  input logic        rst_n,
  mtok_in_if.sink    in_ch,
  mtok_out_if.source out_ch
);

  // Three parts:
  //   front - byte classify + mode machine, produces a bundle of 0..2 results
  //   queue - short FIFO of bundles so front and back stall independently
  //   back  - unpacks a bundle into beats, flags last_of_run on the final one
  // Positions are POSITION_WIDTH wide and saturate; spans leave as 24 bits.

  logic         q_push;
  logic         q_full;
  logic         q_pop;
  logic         q_valid;
  mtok_bundle_t q_wdata;
  mtok_bundle_t q_rdata;

  // output beat flags used by the checks below
  logic         out_eof;
  logic         out_mid;

  mtok_front #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  mtok_queue #(
    .DEPTH(4)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_rdata)
  );

  mtok_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  assign out_eof = out_ch.valid && (out_ch.token_kind == K_EOF);
  assign out_mid = out_ch.valid && out_ch.ready && !out_ch.last_of_run;

  // end of input always yields at least the EOF result
  `MTOK_ASSERT_NOW(a_eof_pushes, in_ch.valid && in_ch.ready && in_ch.op, q_push, "no EOF bundle")
  // EOF closes its run
  `MTOK_ASSERT_NOW(a_eof_last, out_eof, out_ch.last_of_run, "EOF beat not marked last")
  // second beat of a run follows right away
  `MTOK_ASSERT_NEXT(a_run_cont, out_mid, out_ch.valid, "run broken after non-last beat")
  // no push lands while the queue is full
  `MTOK_ASSERT_NOW(a_no_overflow, q_push, !q_full, "bundle pushed into full queue")

endmodule

@@ sim/manifest_tokenizer_test_pkg.sv @@
// Opcodes and character codes shared by the tokenizer testbench modules.
package manifest_tokenizer_test_pkg;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_EOF  = 1'b1;

  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_VTAB       = 8'h0B;
  localparam logic [7:0] CH_FF         = 8'h0C;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_COMMA      = 8'h2C;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_COLON      = 8'h3A;
  localparam logic [7:0] CH_SEMI       = 8'h3B;
  localparam logic [7:0] CH_LBRACK     = 8'h5B;
  localparam logic [7:0] CH_RBRACK     = 8'h5D;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LBRACE     = 8'h7B;
  localparam logic [7:0] CH_RBRACE     = 8'h7D;

endpackage

@@ sim/manifest_tokenizer_checker.sv @@
// Token predictor and result scoreboard for the manifest tokenizer.
module manifest_tokenizer_checker import mtok_pkg::*, manifest_tokenizer_test_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              in_op,
  input  logic [7:0]        in_source_byte,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [KIND_W-1:0] out_token_kind,
  input  logic [SPAN_W-1:0] out_span_start,
  input  logic [SPAN_W-1:0] out_span_end,
  input  logic [DIAG_W-1:0] out_diagnostic,
  input  logic              out_last_of_run,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    LX_IDLE, LX_SLASH, LX_SLASH2, LX_COMMENT, LX_CR, LX_IDENT, LX_STRING
  } lex_mode_t;

  typedef struct packed {
    mtok_res_t tok;
    logic      last;
  } token_exp_t;

  token_exp_t        expected_tokens[$];
  token_exp_t        beat_tokens[$];
  lex_mode_t         mode = LX_IDLE;
  logic [SPAN_W-1:0] begin_pos = '0;
  logic [SPAN_W-1:0] cur_pos = '0;
  int                mismatches = 0;

  function automatic bit is_ident_head(logic [7:0] b);
    return b == CH_UNDERSCORE || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic bit is_ident_char(logic [7:0] b);
    return is_ident_head(b) || (b >= "0" && b <= "9");
  endfunction

  // At most two tokens per beat; anything beyond is dropped.
  function automatic void note_token(logic [KIND_W-1:0] kind, logic [SPAN_W-1:0] s,
                                     logic [SPAN_W-1:0] e, logic [DIAG_W-1:0] d);
    token_exp_t t;
    t.tok.kind       = kind;
    t.tok.span_start = s;
    t.tok.span_end   = e;
    t.tok.diag       = d;
    t.last           = 1'b0;
    if (beat_tokens.size() < 2) beat_tokens.push_back(t);
  endfunction

  // Byte seen between tokens.
  function automatic void start_token(logic [7:0] b, logic [SPAN_W-1:0] p,
                                      logic [SPAN_W-1:0] np);
    begin_pos = p;
    case (b)
      CH_SPACE, CH_TAB, CH_VTAB, CH_FF: ;
      CH_SLASH:  mode = LX_SLASH;
      CH_CR:     mode = LX_CR;
      CH_LF:     note_token(K_NEWLINE, p, np, D_NONE);
      CH_QUOTE:  mode = LX_STRING;
      CH_LBRACE: note_token(K_LBRACE, p, np, D_NONE);
      CH_RBRACE: note_token(K_RBRACE, p, np, D_NONE);
      CH_LBRACK: note_token(K_LBRACK, p, np, D_NONE);
      CH_RBRACK: note_token(K_RBRACK, p, np, D_NONE);
      CH_COLON:  note_token(K_COLON, p, np, D_NONE);
      CH_SEMI:   note_token(K_SEMI, p, np, D_NONE);
      CH_COMMA:  note_token(K_COMMA, p, np, D_NONE);
      default: begin
        if (is_ident_head(b)) mode = LX_IDENT;
        else note_token(K_ERROR, p, np, D_UNRECOGNIZED);
      end
    endcase
  endfunction

  function automatic void predict_beat(logic op, logic [7:0] b);
    logic [SPAN_W-1:0] p;
    logic [SPAN_W-1:0] np;
    bit                brk;
    bit                to_idle;
    token_exp_t        t;
    p       = cur_pos;
    np      = (p == '1) ? p : p + SPAN_W'(1);   // position saturates
    brk     = (b == CH_CR) || (b == CH_LF);
    to_idle = 1'b0;
    beat_tokens.delete();
    if (op == OP_EOF) begin
      // flush whatever is pending, then EOF, then start over
      case (mode)
        LX_SLASH:  note_token(K_ERROR, begin_pos, p, D_UNRECOGNIZED);
        LX_CR:     note_token(K_NEWLINE, begin_pos, p, D_NONE);
        LX_IDENT:  note_token(K_IDENT, begin_pos, p, D_NONE);
        LX_STRING: note_token(K_ERROR, begin_pos, p, D_UNTERMINATED);
        default: ;
      endcase
      note_token(K_EOF, p, p, D_NONE);
      mode      = LX_IDLE;
      begin_pos = '0;
      cur_pos   = '0;
    end else begin
      case (mode)
        LX_SLASH: begin
          if (b == CH_SLASH) mode = LX_SLASH2;
          else begin
            note_token(K_ERROR, begin_pos, p, D_UNRECOGNIZED);
            to_idle = 1'b1;
          end
        end
        LX_SLASH2: begin
          if (brk) to_idle = 1'b1;
          else begin
            if (b == CH_LBRACE) note_token(K_DIAG, begin_pos, np, D_MULTILINE);
            mode = LX_COMMENT;
          end
        end
        LX_COMMENT: to_idle = brk;
        LX_CR: begin
          if (b == CH_LF) begin
            note_token(K_NEWLINE, begin_pos, np, D_NONE);
            mode = LX_IDLE;
          end else begin
            note_token(K_NEWLINE, begin_pos, p, D_NONE);
            to_idle = 1'b1;
          end
        end
        LX_IDENT: begin
          if (!is_ident_char(b)) begin
            note_token(K_IDENT, begin_pos, p, D_NONE);
            to_idle = 1'b1;
          end
        end
        LX_STRING: begin
          if (b == CH_QUOTE) begin
            note_token(K_STRING, begin_pos, np, D_NONE);
            mode = LX_IDLE;
          end else if (brk) begin
            note_token(K_ERROR, begin_pos, p, D_UNTERMINATED);
            to_idle = 1'b1;
          end
        end
        default: to_idle = 1'b1;
      endcase
      if (to_idle) begin
        mode = LX_IDLE;
        start_token(b, p, np);
      end
      cur_pos = np;
    end
    foreach (beat_tokens[i]) begin
      t      = beat_tokens[i];
      t.last = (i == beat_tokens.size() - 1);
      expected_tokens.push_back(t);
    end
  endfunction

  function automatic void check_field(string name, logic [SPAN_W-1:0] expv,
                                      logic [SPAN_W-1:0] actv);
    if (expv !== actv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      mismatches++;
    end
  endfunction

  function automatic void match_token();
    token_exp_t t;
    if (expected_tokens.size() == 0) begin
      $error("token_kind: expected none, got %0d (no token outstanding)", out_token_kind);
      mismatches++;
    end else begin
      t = expected_tokens.pop_front();
      check_field("token_kind", SPAN_W'(t.tok.kind), SPAN_W'(out_token_kind));
      check_field("span_start", t.tok.span_start, out_span_start);
      check_field("span_end", t.tok.span_end, out_span_end);
      check_field("diagnostic", SPAN_W'(t.tok.diag), SPAN_W'(out_diagnostic));
      check_field("last_of_run", SPAN_W'(t.last), SPAN_W'(out_last_of_run));
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) match_token();
      if (in_valid && in_ready) predict_beat(in_op, in_source_byte);
    end
    fail_count <= mismatches;
    pending    <= expected_tokens.size();
  end

endmodule

@@ sim/manifest_tokenizer_test.sv @@
// Top of the manifest tokenizer testbench: clock, reset, stimulus and verdict.
module manifest_tokenizer_test import mtok_pkg::*, manifest_tokenizer_test_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Beats per traffic phase; eight phases give roughly 900 counted beats.
  localparam int PHASE_BEATS  = 112;
  // Long receiver hold-off, well past the 4-deep bundle queue.
  localparam int HOLD_CYCLES  = 300;
  // Cycles waited after the drain to catch stray results.
  localparam int DRAIN_CYCLES = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mtok_in_if  in_ch ();
  mtok_out_if out_ch ();

  int fail_count;
  int pending;

  int send_idle_pct  = 0;   // chance per cycle the sender sits out
  int recv_stall_pct = 0;   // chance per cycle the receiver drops ready
  bit hold_request   = 1'b0;
  int beats_counted  = 0;   // beats other than blank bytes

  // Stimulus script: {op, byte} per beat.
  logic [8:0] script[$];

  string      ident_head = "_abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
  string      ident_tail = "_abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
  logic [7:0] blank_set[4] = '{CH_SPACE, CH_TAB, CH_VTAB, CH_FF};
  logic [7:0] punct_set[7] = '{CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK,
                               CH_COLON, CH_SEMI, CH_COMMA};

  always #5 clk = ~clk;

  manifest_tokenizer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  manifest_tokenizer_checker CHK (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_op           (in_ch.op),
    .in_source_byte  (in_ch.source_byte),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_token_kind  (out_ch.token_kind),
    .out_span_start  (out_ch.span_start),
    .out_span_end    (out_ch.span_end),
    .out_diagnostic  (out_ch.diagnostic),
    .out_last_of_run (out_ch.last_of_run),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  function automatic bit is_blank(logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_VTAB || b == CH_FF;
  endfunction

  function automatic void push_byte(logic [7:0] b);
    script.push_back({OP_BYTE, b});
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  // End of input; the byte lane carries junk that must be ignored.
  function automatic void push_eof();
    logic [7:0] junk;
    junk = 8'($urandom_range(255));
    script.push_back({OP_EOF, junk});
  endfunction

  // Any byte that keeps a string or comment open.
  function automatic logic [7:0] body_byte(bit in_string);
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == CH_CR || b == CH_LF || (in_string && b == CH_QUOTE));
    return b;
  endfunction

  // Mostly well-formed manifest text with random content, some broken
  // constructs and raw noise mixed in.
  function automatic void compose_fragment();
    int pick;
    int len;
    pick = $urandom_range(99);
    if (pick < 20) begin
      push_byte(ident_head[$urandom_range(ident_head.len() - 1)]);
      len = $urandom_range(7);
      repeat (len) push_byte(ident_tail[$urandom_range(ident_tail.len() - 1)]);
    end else if (pick < 32) begin
      // string, cut short by a line break or end of input now and then
      push_byte(CH_QUOTE);
      len = $urandom_range(6);
      repeat (len) push_byte(body_byte(1'b1));
      case ($urandom_range(9))
        0:       push_byte(CH_LF);
        1:       push_byte(CH_CR);
        2:       push_eof();
        default: push_byte(CH_QUOTE);
      endcase
    end else if (pick < 50) begin
      push_byte(punct_set[$urandom_range(6)]);
    end else if (pick < 60) begin
      len = $urandom_range(1, 3);
      repeat (len) push_byte(blank_set[$urandom_range(3)]);
    end else if (pick < 70) begin
      case ($urandom_range(2))
        0: push_byte(CH_LF);
        1: push_byte(CH_CR);
        default: begin
          push_byte(CH_CR);
          push_byte(CH_LF);
        end
      endcase
    end else if (pick < 77) begin
      // line comment, sometimes opening with the multiline marker
      push_byte(CH_SLASH);
      push_byte(CH_SLASH);
      if ($urandom_range(2) == 0) push_byte(CH_LBRACE);
      len = $urandom_range(5);
      repeat (len) push_byte(body_byte(1'b0));
      case ($urandom_range(5))
        0:       push_byte(CH_CR);
        1:       push_eof();
        default: push_byte(CH_LF);
      endcase
    end else if (pick < 81) begin
      push_byte(CH_SLASH);   // lone slash unless the next fragment adds one
    end else if (pick < 84) begin
      push_eof();
    end else begin
      push_byte(8'($urandom_range(255)));
    end
  endfunction

  // One beat. valid stays high from beat to beat unless an idle cycle is
  // drawn, so it never gets two updates in one time step.
  task automatic send_beat(logic op, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.source_byte <= b;
    do @(posedge clk);
    while (!in_ch.ready);
    if (op == OP_EOF || !is_blank(b)) beats_counted++;
  endtask

  task automatic play_script();
    logic [8:0] beat;
    while (script.size() > 0) begin
      beat = script.pop_front();
      send_beat(beat[8], beat[7:0]);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request, counted here
  // so the sender keeps pushing and the block backs up into its input.
  initial begin
    int held;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    int phase;
    int target;
    in_ch.valid       <= 1'b0;
    in_ch.op          <= OP_BYTE;
    in_ch.source_byte <= 8'h00;
    rst_n             <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: byte extremes, all punctuation, empty string, identifier
    // ended by a blank, CR LF, lone CR, lone slash, the multiline comment
    // marker, a string broken by CR, a string broken by end of input.
    push_byte(8'h00);
    push_byte(8'hFF);
    push_text("{}[]:;,");
    push_byte(CH_QUOTE);
    push_byte(CH_QUOTE);
    push_text("_Z");
    push_byte(CH_FF);
    push_byte(CH_CR);
    push_byte(CH_LF);
    push_byte(CH_CR);
    push_text("/a");
    push_text("//{");
    push_byte(CH_LF);
    push_byte(CH_QUOTE);
    push_byte(CH_CR);
    push_byte(CH_QUOTE);
    push_eof();
    play_script();

    // Random traffic, cycling through the idle/stall mixes twice.
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          if (phase == 0) hold_request = 1'b1;
        end
        1: begin
          send_idle_pct  = 76;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 76;
        end
        default: begin
          send_idle_pct  = 10;
          recv_stall_pct = 10;
        end
      endcase
      target = beats_counted + PHASE_BEATS;
      while (beats_counted < target) begin
        compose_fragment();
        play_script();
      end
    end

    in_ch.valid    <= 1'b0;
    recv_stall_pct = 0;
    do @(posedge clk);
    while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far above the slowest legal run.
  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ manifest_tokenizer.f @@
+incdir+hdl
hdl/mtok_pkg.sv
hdl/mtok_ifs.sv
hdl/mtok_front.sv
hdl/mtok_queue.sv
hdl/mtok_back.sv
hdl/manifest_tokenizer.sv
sim/manifest_tokenizer_test_pkg.sv
sim/manifest_tokenizer_checker.sv
sim/manifest_tokenizer_test.sv
